@@ sv/scpr_pkg.sv @@
package scpr_pkg;

  // Payload widths of the request and response channels
  localparam int unsigned REQ_TYPE_W   = 1;
  localparam int unsigned SLOT_COUNT_W = 16;
  localparam int unsigned PORT_HANDLE_W = 48;

  // Request type codes
  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Per-request decision from the fill bank
  typedef struct packed {
    logic hit;
    logic push;
    logic pop;
  } scpr_ctl_t;

endpackage

@@ sv/scpr_if.sv @@
interface scpr_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [scpr_pkg::REQ_TYPE_W-1:0]        req_type;
  logic [scpr_pkg::SLOT_COUNT_W-1:0]      slot_count;
  logic [scpr_pkg::PORT_HANDLE_W-1:0]     handle_in;

  modport source (output valid, output req_type, output slot_count, output handle_in,
                  input ready);
  modport sink   (input valid, input req_type, input slot_count, input handle_in,
                  output ready);
endinterface

interface scpr_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   cache_hit;
  logic [scpr_pkg::PORT_HANDLE_W-1:0]     handle_out;
  logic                                   needs_system;

  modport source (output valid, output cache_hit, output handle_out, output needs_system,
                  input ready);
  modport sink   (input valid, input cache_hit, input handle_out, input needs_system,
                  output ready);
endinterface

@@ sv/scpr_fill.sv @@
module scpr_fill #(
  parameter int unsigned NUM_CLASSES = 8,
  parameter int unsigned CLASS_DEPTH = 64,
  parameter int unsigned ADDR_W      = 9
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  fire,
  input  logic [scpr_pkg::REQ_TYPE_W-1:0]       req_type,
  input  logic [scpr_pkg::SLOT_COUNT_W-1:0]     slot_count,
  output scpr_pkg::scpr_ctl_t                   ctl,
  output logic [ADDR_W-1:0]                     addr
);

  localparam int unsigned CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned IDX_W  = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(CLASS_DEPTH + 1);

  logic [FILL_W-1:0]                   class_fill [NUM_CLASSES];
  logic [scpr_pkg::SLOT_COUNT_W-1:0]   cls_wide;
  logic                                cls_valid;
  logic [CLS_W-1:0]                    cls;
  logic [FILL_W-1:0]                   fill;
  logic [FILL_W-1:0]                   slot;
  logic                                is_release;

  assign cls_wide   = slot_count - scpr_pkg::SLOT_COUNT_W'(1);
  assign cls_valid  = (slot_count != '0) &&
                      (cls_wide < scpr_pkg::SLOT_COUNT_W'(NUM_CLASSES));
  assign cls        = cls_valid ? CLS_W'(cls_wide) : '0;
  assign fill       = class_fill[cls];
  assign is_release = (req_type == scpr_pkg::REQ_RELEASE);

  always_comb begin
    ctl.push = cls_valid && is_release && (fill < FILL_W'(CLASS_DEPTH));
    ctl.pop  = cls_valid && !is_release && (fill != '0);
    ctl.hit  = ctl.push || ctl.pop;
  end

  // push writes at the current top, pop reads one below it
  assign slot = ctl.pop ? (fill - FILL_W'(1)) : fill;
  assign addr = ADDR_W'(cls) * ADDR_W'(CLASS_DEPTH) + ADDR_W'(slot[IDX_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        class_fill[i] <= '0;
      end
    end else if (fire && ctl.push) begin
      class_fill[cls] <= fill + FILL_W'(1);
    end else if (fire && ctl.pop) begin
      class_fill[cls] <= fill - FILL_W'(1);
    end
  end

endmodule

@@ sv/scpr_store.sv @@
module scpr_store #(
  parameter int unsigned DEPTH   = 512,
  parameter int unsigned ADDR_W  = 9,
  parameter int unsigned WIDTH   = 48
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ sv/size_class_page_recycler_unit.sv @@
// The response is registered and presented in the cycle after a request is accepted.
// Throughput: one request per cycle while the response is not stalled; the fill counts update at acceptance,
// so a pop right after a push to the same class reads the freshly written entry.
// Handle storage is a single-port memory with a registered read.
// Reset (rst, synchronous) empties every class stack and drops any pending response.
module size_class_page_recycler_unit #(
  parameter int unsigned NUM_CLASSES  = 8,
  parameter int unsigned CLASS_DEPTH  = 64,
  parameter int unsigned HANDLE_WIDTH = 48
) (
  input  logic        clk,
  input  logic        rst,
  scpr_req_if.sink    req,
  scpr_rsp_if.source  rsp
);

  localparam int unsigned STORE_DEPTH = NUM_CLASSES * CLASS_DEPTH;
  localparam int unsigned ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  scpr_pkg::scpr_ctl_t      ctl;
  logic [ADDR_W-1:0]        addr;
  logic [HANDLE_WIDTH-1:0]  rdata;
  logic                     fire;
  logic                     out_valid;
  logic                     hit_q;
  logic                     pop_q;

  assign req.ready = !out_valid || rsp.ready;
  assign fire      = req.valid && req.ready;

  scpr_fill #(
    .NUM_CLASSES (NUM_CLASSES),
    .CLASS_DEPTH (CLASS_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_fill (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .req_type   (req.req_type),
    .slot_count (req.slot_count),
    .ctl        (ctl),
    .addr       (addr)
  );

  scpr_store #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W),
    .WIDTH  (HANDLE_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (fire && ctl.push),
    .re    (fire && ctl.pop),
    .addr  (addr),
    .wdata (HANDLE_WIDTH'(req.handle_in)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // rdata only changes on a pop, which needs a free output slot
  always_ff @(posedge clk) begin
    if (fire) begin
      hit_q <= ctl.hit;
      pop_q <= ctl.pop;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.cache_hit    = hit_q;
  assign rsp.needs_system = !hit_q;
  assign rsp.handle_out   = pop_q ? scpr_pkg::PORT_HANDLE_W'(rdata) : '0;

  a_resp_follows: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp.valid)
    else $error("accepted request produced no response");

  a_no_accept_stalled: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |-> !fire)
    else $error("request accepted while response stalled");

  a_push_pop_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.push, ctl.pop}))
    else $error("push and pop in the same cycle");

  a_miss_zero_handle: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.cache_hit) |-> (rsp.handle_out == '0))
    else $error("nonzero handle on a miss");

endmodule

@@ dv/page_recycler_checker.sv @@
`timescale 1ns / 100ps

module page_recycler_checker #(
  parameter int unsigned NUM_CLASSES  = 8,
  parameter int unsigned CLASS_DEPTH  = 64,
  parameter int unsigned HANDLE_WIDTH = 48
) (
  input  logic clk,
  input  logic rst,
  scpr_req_if  req,
  scpr_rsp_if  rsp,
  output int   fail_count,
  output int   pending,
  output int   answered,
  output int   pop_hits,
  output int   full_refusals,
  output int   uncached
);

  localparam int unsigned FILL_W = $clog2(CLASS_DEPTH + 1);
  // handles are cut to the block's handle width
  localparam logic [scpr_pkg::PORT_HANDLE_W-1:0] HANDLE_KEEP =
    {scpr_pkg::PORT_HANDLE_W{1'b1}} >> (scpr_pkg::PORT_HANDLE_W - HANDLE_WIDTH);

  typedef struct packed {
    logic                               cache_hit;
    logic [scpr_pkg::PORT_HANDLE_W-1:0] handle_out;
    logic                               needs_system;
  } page_rsp_t;

  logic [FILL_W-1:0]                  class_fill [NUM_CLASSES];
  logic [scpr_pkg::PORT_HANDLE_W-1:0] page_store [NUM_CLASSES * CLASS_DEPTH];
  page_rsp_t                          expected_rsp [$];

  // Updates the class stacks for one request and returns its response.
  function automatic page_rsp_t recycle_page(
      input logic                               kind,
      input logic [scpr_pkg::SLOT_COUNT_W-1:0]  slots,
      input logic [scpr_pkg::PORT_HANDLE_W-1:0] handle);
    page_rsp_t         r;
    int unsigned       cls;
    logic [FILL_W-1:0] fill;
    r = '0;
    r.needs_system = 1'b1;
    if (slots >= 1 && slots <= NUM_CLASSES) begin
      cls  = slots - 1;
      fill = class_fill[cls];
      if (kind == scpr_pkg::REQ_RELEASE) begin
        if (fill < CLASS_DEPTH) begin
          page_store[cls * CLASS_DEPTH + fill] = handle & HANDLE_KEEP;
          class_fill[cls] = fill + 1'b1;
          r.cache_hit    = 1'b1;
          r.needs_system = 1'b0;
        end else begin
          full_refusals++;
        end
      end else if (fill != 0) begin
        fill            = fill - 1'b1;
        r.handle_out    = page_store[cls * CLASS_DEPTH + fill];
        class_fill[cls] = fill;
        r.cache_hit     = 1'b1;
        r.needs_system  = 1'b0;
        pop_hits++;
      end
    end else begin
      uncached++;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    page_rsp_t want;
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) class_fill[i] = '0;
      expected_rsp.delete();
      answered      = 0;
      pop_hits      = 0;
      full_refusals = 0;
      uncached      = 0;
    end else begin
      // response first: it is checked before a request accepted alongside it is queued
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        answered++;
        if (expected_rsp.size() == 0) begin
          $error("response with no request outstanding");
          fail_count++;
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.cache_hit !== want.cache_hit) begin
            $error("cache_hit: expected %0b, got %0b", want.cache_hit, rsp.cache_hit);
            fail_count++;
          end
          if (rsp.handle_out !== want.handle_out) begin
            $error("handle_out: expected %h, got %h", want.handle_out, rsp.handle_out);
            fail_count++;
          end
          if (rsp.needs_system !== want.needs_system) begin
            $error("needs_system: expected %0b, got %0b", want.needs_system,
                   rsp.needs_system);
            fail_count++;
          end
        end
      end
      if (req.valid === 1'b1 && req.ready === 1'b1)
        expected_rsp.push_back(recycle_page(req.req_type, req.slot_count, req.handle_in));
    end
    pending = expected_rsp.size();
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned NUM_CLASSES  = 8;
  localparam int unsigned CLASS_DEPTH  = 64;
  localparam int unsigned HANDLE_WIDTH = 48;
  localparam int unsigned ITEM_TARGET  = 400;
  localparam int unsigned QUIET_ITEMS  = 60;
  localparam int unsigned HOLD_CYCLES  = 150;

  logic        clk;
  logic        rst;
  logic        quiet;
  logic        hold_rsp;
  int unsigned sent;
  int          fail_count, pending, answered, pop_hits, full_refusals, uncached;

  scpr_req_if req_ch();
  scpr_rsp_if rsp_ch();

  size_class_page_recycler_unit #(
    .NUM_CLASSES (NUM_CLASSES),
    .CLASS_DEPTH (CLASS_DEPTH),
    .HANDLE_WIDTH(HANDLE_WIDTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  page_recycler_checker #(
    .NUM_CLASSES (NUM_CLASSES),
    .CLASS_DEPTH (CLASS_DEPTH),
    .HANDLE_WIDTH(HANDLE_WIDTH)
  ) i_chk (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .answered     (answered),
    .pop_hits     (pop_hits),
    .full_refusals(full_refusals),
    .uncached     (uncached)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

  function automatic logic [scpr_pkg::PORT_HANDLE_W-1:0] rand_handle();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[scpr_pkg::PORT_HANDLE_W-1:0];
  endfunction

  task automatic pause_sender(input int unsigned cycles);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic send_request(input logic kind,
                              input logic [scpr_pkg::SLOT_COUNT_W-1:0] slots,
                              input logic [scpr_pkg::PORT_HANDLE_W-1:0] handle);
    if (!quiet && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 13));
    @(negedge clk);
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.slot_count <= slots;
    req_ch.handle_in  <= handle;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sent++;
  endtask

  task automatic wait_until_drained();
    pause_sender(1);
    while (pending != 0) @(negedge clk);
  endtask

  // One burst: mostly a single class with a random push/pop mix, sometimes noise.
  task automatic run_mixed_burst();
    int unsigned                       mode, len, release_pct;
    logic [scpr_pkg::SLOT_COUNT_W-1:0] slots;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      len = $urandom_range(1, 5);
      repeat (len) begin
        slots = ($urandom_range(0, 3) == 0) ? '0 :
                scpr_pkg::SLOT_COUNT_W'($urandom_range(0, 65535));
        send_request(1'($urandom_range(0, 1)), slots, rand_handle());
      end
    end else begin
      slots       = scpr_pkg::SLOT_COUNT_W'($urandom_range(1, NUM_CLASSES));
      release_pct = (mode < 4) ? 20 : (mode < 7) ? 50 : 80;
      len         = $urandom_range(4, 30);
      repeat (len)
        send_request(($urandom_range(0, 99) < release_pct) ? scpr_pkg::REQ_RELEASE
                                                            : scpr_pkg::REQ_ALLOC,
                     slots, rand_handle());
    end
  endtask

  // response side: random stalls, one long hold on request
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_rsp = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20) - 1) @(negedge clk);
      end
    end
  end

  initial begin
    logic [scpr_pkg::SLOT_COUNT_W-1:0] fill_slots;
    rst                 = 1'b1;
    quiet               = 1'b0;
    hold_rsp            = 1'b0;
    sent                = 0;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = scpr_pkg::REQ_ALLOC;
    req_ch.slot_count   = '0;
    req_ch.handle_in    = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed: empty stack, no size class, extreme handles, push then pop
    send_request(scpr_pkg::REQ_ALLOC,   16'd1,     rand_handle());
    send_request(scpr_pkg::REQ_ALLOC,   16'd0,     rand_handle());
    send_request(scpr_pkg::REQ_RELEASE, 16'd0,     48'hFFFF_FFFF_FFFF);
    send_request(scpr_pkg::REQ_RELEASE, 16'hFFFF,  48'h0);
    send_request(scpr_pkg::REQ_ALLOC,   16'hFFFF,  rand_handle());
    send_request(scpr_pkg::REQ_ALLOC,   16'd9,     rand_handle());
    send_request(scpr_pkg::REQ_RELEASE, 16'd1,     48'hFFFF_FFFF_FFFF);
    send_request(scpr_pkg::REQ_RELEASE, 16'd1,     48'h0);
    send_request(scpr_pkg::REQ_ALLOC,   16'd1,     48'hFFFF_FFFF_FFFF);
    send_request(scpr_pkg::REQ_ALLOC,   16'd1,     rand_handle());
    send_request(scpr_pkg::REQ_ALLOC,   16'd1,     rand_handle());
    for (int c = 1; c <= NUM_CLASSES; c++)
      send_request(scpr_pkg::REQ_RELEASE, scpr_pkg::SLOT_COUNT_W'(c),
                   (c % 2) ? 48'hAAAA_AAAA_AAAA ^ scpr_pkg::PORT_HANDLE_W'(c)
                           : 48'h5555_5555_5555 ^ scpr_pkg::PORT_HANDLE_W'(c));
    for (int c = NUM_CLASSES; c >= 1; c--)
      send_request(scpr_pkg::REQ_ALLOC, scpr_pkg::SLOT_COUNT_W'(c), rand_handle());

    // fill one class past full, starting while responses are held off, then drain it past empty
    fill_slots = scpr_pkg::SLOT_COUNT_W'($urandom_range(1, NUM_CLASSES));
    hold_rsp   = 1'b1;
    repeat (CLASS_DEPTH + 2) send_request(scpr_pkg::REQ_RELEASE, fill_slots, rand_handle());
    wait_until_drained();
    repeat (CLASS_DEPTH + 2) send_request(scpr_pkg::REQ_ALLOC, fill_slots, rand_handle());

    while (sent < ITEM_TARGET - QUIET_ITEMS) run_mixed_burst();
    quiet = 1'b1;
    while (sent < ITEM_TARGET) run_mixed_burst();

    wait_until_drained();
    repeat (4) @(negedge clk);
    $display("run: %0d requests answered, %0d pops from a class stack", answered, pop_hits);
    $display("run: %0d releases refused by a full class, %0d requests with no size class",
             full_refusals, uncached);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/scpr_pkg.sv
sv/scpr_if.sv
sv/scpr_fill.sv
sv/scpr_store.sv
sv/size_class_page_recycler_unit.sv
dv/page_recycler_checker.sv
dv/tb_top.sv
